// ----- design/smm_pkg.sv -----
// Shared constants, types and helpers for the sliding min/max/median filter.
`timescale 1ns / 1ps
`default_nettype none

package smm_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int MAX_WINDOW   = 7;
    localparam int COUNT_W      = $clog2(MAX_WINDOW + 1);
    localparam int RANK_W       = $clog2(MAX_WINDOW);
    localparam int RADIUS_W     = 2;
    localparam int RADIUS_CAP   = (MAX_WINDOW - 1) / 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_WINDOW);

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic [RADIUS_W-1:0]            radius_t;
    typedef logic [COUNT_W-1:0]             count_t;
    typedef logic [RANK_W-1:0]              rank_t;

    // Effective radius: zero acts as one, oversize windows are capped.
    function automatic radius_t radius_of(radius_t hw);
        radius_t h;
        h = (hw == '0) ? RADIUS_W'(1) : hw;
        if ((2 * int'(h) + 1) > MAX_WINDOW)
        begin
            h = RADIUS_W'(RADIUS_CAP);
        end
        return h;
    endfunction

endpackage

`default_nettype wire

// ----- design/sliding_min_max_median_filter_unit.sv -----
// Top level of the sliding-window min/max/median filter.
`timescale 1ns / 1ps
`default_nettype none

// Centred-window filter over a stream of signed samples. For each stream
// position it returns the minimum, maximum and median of a zero-padded window
// of 2*half_width+1 samples (3, 5 or 7; half_width of 0 acts as 1). The result
// for a position leaves once the sample half_width places later has been
// taken. A sample with last set flushes the remaining positions with zero
// padding, flags the final result with end_of_run, and clears the delay line
// for the next stream. Rate: one sample transaction per cycle for ordinary
// samples while the result side keeps up; a last sample holds sample_stall
// high while the zero shifts run through the delay line, one shift per cycle
// while the result side keeps up. Results are ranked by a combinational
// all-pairs comparator array between the window register and the result
// register, which loads a ranked window once it is free. Either side may
// stall at any time; the result register decouples the two channels.
// half_width is written through cfg_write_enable/cfg_write_data and must only
// change while the block is idle.
module sliding_min_max_median_filter_unit
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // configuration
    input  wire logic                    cfg_write_enable,
    input  wire smm_pkg::radius_t        cfg_write_data,
    // sample channel
    input  wire logic                    sample_valid,
    output logic                         sample_stall,
    input  wire smm_pkg::sample_t        sample,
    input  wire logic                    last,
    // result channel
    output logic                         result_valid,
    input  wire logic                    result_stall,
    output smm_pkg::sample_t             min_value,
    output smm_pkg::sample_t             max_value,
    output smm_pkg::sample_t             median_value,
    output logic                         end_of_run
);

    localparam int W = smm_pkg::MAX_WINDOW;

    // Configuration register
    smm_pkg::radius_t half_width_reg;
    smm_pkg::radius_t radius;

    // Delay line, newest sample at index 0, and stream bookkeeping
    smm_pkg::sample_t line_reg  [W];
    smm_pkg::sample_t line_next [W];
    smm_pkg::sample_t base_line [W];
    smm_pkg::count_t  seen_reg, seen_next, base_seen, seen_inc, threshold;
    smm_pkg::radius_t flush_left_reg, flush_left_next;

    // A window in the delay line waiting to be ranked
    logic job_valid_reg, job_valid_next;
    logic job_end_reg,   job_end_next;

    // Result register
    logic             result_valid_reg;
    smm_pkg::sample_t min_reg, max_reg, median_reg;
    logic             end_reg;

    // Handshake and sequencing
    logic             out_ready, eval_go, line_free, flushing, take;
    logic             clear_now, do_shift;
    smm_pkg::sample_t shift_val;

    // Ranking
    smm_pkg::count_t  win_size;
    logic             in_win   [W];
    smm_pkg::rank_t   rank     [W];
    smm_pkg::sample_t min_sel, max_sel, median_sel;

    assign radius    = smm_pkg::radius_of(half_width_reg);
    assign threshold = smm_pkg::count_t'(radius) + smm_pkg::count_t'(1);
    assign win_size  = (smm_pkg::count_t'(radius) << 1) + smm_pkg::count_t'(1);

    // The window can be ranked whenever the result register frees up; the
    // delay line may only move once its pending window has been ranked.
    assign out_ready    = !result_valid_reg || !result_stall;
    assign eval_go      = job_valid_reg && out_ready;
    assign line_free    = !job_valid_reg || out_ready;
    assign flushing     = (flush_left_reg != '0);
    assign sample_stall = flushing || !line_free;
    assign take         = sample_valid && !sample_stall;

    // End-of-stream window leaves this cycle: the line restarts from zero.
    assign clear_now = eval_go && job_end_reg;
    assign base_seen = clear_now ? '0 : seen_reg;
    assign seen_inc  = (base_seen == smm_pkg::COUNT_MAX) ? base_seen
                                                         : base_seen + smm_pkg::count_t'(1);
    assign do_shift  = take || (flushing && line_free);
    assign shift_val = flushing ? '0 : sample;

    always_comb
    begin
        for (int i = 0; i < W; i++)
        begin
            base_line[i] = clear_now ? '0 : line_reg[i];
        end

        for (int i = 0; i < W; i++)
        begin
            line_next[i] = base_line[i];
        end
        seen_next       = base_seen;
        job_valid_next  = job_valid_reg && !eval_go;
        job_end_next    = job_end_reg && !eval_go;
        flush_left_next = flush_left_reg;

        if (do_shift)
        begin
            line_next[0] = shift_val;
            for (int i = 1; i < W; i++)
            begin
                line_next[i] = base_line[i-1];
            end
            seen_next      = seen_inc;
            job_valid_next = (seen_inc >= threshold);
            job_end_next   = flushing && (flush_left_reg == smm_pkg::radius_t'(1));
            if (flushing)
            begin
                flush_left_next = flush_left_reg - smm_pkg::radius_t'(1);
            end
            else if (last)
            begin
                flush_left_next = radius;
            end
        end
    end

    // All-pairs ranking; ties broken by position so ranks are unique.
    always_comb
    begin
        for (int i = 0; i < W; i++)
        begin
            in_win[i] = (smm_pkg::count_t'(i) < win_size);
        end

        for (int i = 0; i < W; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < W; j++)
            begin
                if ((j != i) && in_win[j] &&
                    ((line_reg[j] < line_reg[i]) ||
                     ((line_reg[j] == line_reg[i]) && (j < i))))
                begin
                    rank[i] = rank[i] + smm_pkg::rank_t'(1);
                end
            end
        end

        min_sel    = '0;
        max_sel    = '0;
        median_sel = '0;
        for (int i = 0; i < W; i++)
        begin
            if (in_win[i] && (rank[i] == '0))
            begin
                min_sel = min_sel | line_reg[i];
            end
            if (in_win[i] && (rank[i] == smm_pkg::rank_t'(win_size - smm_pkg::count_t'(1))))
            begin
                max_sel = max_sel | line_reg[i];
            end
            if (in_win[i] && (rank[i] == smm_pkg::rank_t'(radius)))
            begin
                median_sel = median_sel | line_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg   <= smm_pkg::radius_t'(1);
            for (int i = 0; i < W; i++)
            begin
                line_reg[i] <= '0;
            end
            seen_reg         <= '0;
            flush_left_reg   <= '0;
            job_valid_reg    <= 1'b0;
            job_end_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_enable)
            begin
                half_width_reg <= cfg_write_data;
            end
            for (int i = 0; i < W; i++)
            begin
                line_reg[i] <= line_next[i];
            end
            seen_reg       <= seen_next;
            flush_left_reg <= flush_left_next;
            job_valid_reg  <= job_valid_next;
            job_end_reg    <= job_end_next;
            if (out_ready)
            begin
                result_valid_reg <= job_valid_reg;
            end
        end
    end

    // Result payload, loaded only when a window is ranked
    always_ff @(posedge clk)
    begin
        if (eval_go)
        begin
            min_reg    <= min_sel;
            max_reg    <= max_sel;
            median_reg <= median_sel;
            end_reg    <= job_end_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign min_value    = min_reg;
    assign max_value    = max_reg;
    assign median_value = median_reg;
    assign end_of_run   = end_reg;

endmodule

`default_nettype wire

// ----- design/smm_checker.sv -----
// Port-level checker for the sliding min/max/median filter, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module smm_checker
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             sample_valid,
    input wire logic             sample_stall,
    input wire logic             last,
    input wire logic             result_valid,
    input wire logic             result_stall,
    input wire smm_pkg::sample_t min_value,
    input wire smm_pkg::sample_t max_value,
    input wire smm_pkg::sample_t median_value,
    input wire logic             end_of_run
);

    // A stalled result transaction stays offered.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    // A stalled result transaction keeps its payload.
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            $stable(min_value) && $stable(max_value) &&
            $stable(median_value) && $stable(end_of_run))
        else $error("result payload changed while stalled");

    // Ranking must order the three statistics.
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (min_value <= median_value) && (median_value <= max_value))
        else $error("min/median/max out of order");

    // A last sample starts a flush, so the next sample cannot be taken at once.
    a_flush_stall: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall && last |=> sample_stall)
        else $error("sample taken during end-of-stream flush");

endmodule

bind sliding_min_max_median_filter_unit smm_checker u_smm_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .last         (last),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .min_value    (min_value),
    .max_value    (max_value),
    .median_value (median_value),
    .end_of_run   (end_of_run)
);

`default_nettype wire

// ----- tb/tb_sliding_min_max_median_filter_unit.sv -----
// Self-checking testbench for the sliding-window min/max/median filter unit.
`timescale 1ns / 1ps

// Stimulus is a queue of pending sample transactions filled by the initial
// block. A clocked driver offers them at the falling edge. A clocked block at
// the rising edge sees the accepted transactions, runs the window predictor on
// them and checks every accepted result against the oldest expected window.
// The radius register is only written once all expected results are back and
// a few settle cycles have passed.
module tb_sliding_min_max_median_filter_unit;

    localparam int CLK_HALF       = 5;
    localparam int IDLE_PCT       = 34;
    localparam int SETTLE_CYCLES  = 10;     // settle wait after each drain
    localparam int HOLD_CYCLES    = 80;     // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no transaction at all
    localparam int MAX_REPORTS    = 40;

    typedef struct
    {
        smm_pkg::sample_t value;
        logic             last;
    } item_t;

    typedef struct
    {
        smm_pkg::sample_t lo;
        smm_pkg::sample_t hi;
        smm_pkg::sample_t mid;
        logic             eor;
    } stats_t;

    // DUT connections, the inputs at known values from time zero
    logic             clk              = 1'b0;
    logic             rst_n            = 1'b0;
    logic             cfg_write_enable = 1'b0;
    smm_pkg::radius_t cfg_write_data   = '0;
    logic             sample_valid     = 1'b0;
    logic             sample_stall;
    smm_pkg::sample_t sample           = '0;
    logic             last             = 1'b0;
    logic             result_valid;
    logic             result_stall     = 1'b0;
    smm_pkg::sample_t min_value;
    smm_pkg::sample_t max_value;
    smm_pkg::sample_t median_value;
    logic             end_of_run;

    // pending sample transactions and expected windows
    item_t  pend_q [$];
    stats_t window_q [$];

    // predictor state: tap line newest first, samples in stream, radius reg
    smm_pkg::sample_t taps [smm_pkg::MAX_WINDOW];
    int               seen_n = 0;
    smm_pkg::radius_t hw_reg = smm_pkg::radius_t'(1);

    // control of idling and of the hold-off
    bit send_idle_en = 1'b1;
    bit recv_idle_en = 1'b1;
    bit hold_go      = 1'b0;
    bit hold_done    = 1'b0;
    int hold_left    = 0;

    logic  in_taken = 1'b0;
    item_t nxt_item;
    int    err_cnt     = 0;
    int    items_in    = 0;
    int    results_out = 0;
    int    streams     = 0;
    int    quiet_cycles = 0;

    sliding_min_max_median_filter_unit dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .sample_valid     (sample_valid),
        .sample_stall     (sample_stall),
        .sample           (sample),
        .last             (last),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .min_value        (min_value),
        .max_value        (max_value),
        .median_value     (median_value),
        .end_of_run       (end_of_run)
    );

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // ------------------------------------------------------------------
    // Window predictor
    // ------------------------------------------------------------------

    // Radius in use: zero acts as one, a window wider than the tap line is cut.
    function automatic int eff_radius(smm_pkg::radius_t hw);
        int h;
        h = (hw == '0) ? 1 : int'(hw);
        if (2 * h + 1 > smm_pkg::MAX_WINDOW)
        begin
            h = (smm_pkg::MAX_WINDOW - 1) / 2;
        end
        return h;
    endfunction

    task automatic shift_tap(smm_pkg::sample_t v);
        for (int i = smm_pkg::MAX_WINDOW - 1; i > 0; i--)
        begin
            taps[i] = taps[i - 1];
        end
        taps[0] = v;
        if (seen_n < int'(smm_pkg::COUNT_MAX))
        begin
            seen_n++;
        end
    endtask

    // Sort the newest 2h+1 taps; min, max and median fall out of the order.
    function automatic stats_t window_stats(int h, logic eor);
        smm_pkg::sample_t w [smm_pkg::MAX_WINDOW];
        smm_pkg::sample_t key;
        stats_t           r;
        int               n;
        int               j;
        n = 2 * h + 1;
        for (int i = 0; i < smm_pkg::MAX_WINDOW; i++)
        begin
            w[i] = taps[i];
        end
        for (int i = 1; i < n; i++)
        begin
            key = w[i];
            j = i;
            while (j > 0 && w[j - 1] > key)
            begin
                w[j] = w[j - 1];
                j--;
            end
            w[j] = key;
        end
        r.lo  = w[0];
        r.hi  = w[n - 1];
        r.mid = w[h];
        r.eor = eor;
        return r;
    endfunction

    // One accepted sample: a window completes once h samples follow its
    // centre; a last sample pads with h zeros and clears for the next stream.
    task automatic predict_windows(smm_pkg::sample_t s, logic lst);
        int h;
        h = eff_radius(hw_reg);
        shift_tap(s);
        if (seen_n >= h + 1)
        begin
            window_q.push_back(window_stats(h, 1'b0));
        end
        if (lst)
        begin
            for (int k = 0; k < h; k++)
            begin
                shift_tap('0);
                if (seen_n >= h + 1)
                begin
                    window_q.push_back(window_stats(h, (k + 1 == h)));
                end
            end
            for (int i = 0; i < smm_pkg::MAX_WINDOW; i++)
            begin
                taps[i] = '0;
            end
            seen_n = 0;
            streams++;
        end
    endtask

    task automatic flag_mismatch(string msg);
        if (err_cnt < MAX_REPORTS)
        begin
            $display("MISMATCH @%0t: %s", $realtime, msg);
        end
        err_cnt++;
    endtask

    // ------------------------------------------------------------------
    // Rising edge: accepted transactions, checks, watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        in_taken <= sample_valid && !sample_stall;
        if (rst_n)
        begin
            // radius register follows the write port
            if (cfg_write_enable)
            begin
                hw_reg = cfg_write_data;
            end
            if (sample_valid && !sample_stall)
            begin
                items_in++;
                predict_windows(sample, last);
            end
            if (result_valid && !result_stall)
            begin
                if (window_q.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected result min=%0d max=%0d med=%0d eor=%b",
                                            min_value, max_value, median_value, end_of_run));
                end
                else
                begin
                    stats_t want;
                    want = window_q.pop_front();
                    if (min_value !== want.lo)
                        flag_mismatch($sformatf("result %0d min_value got %0d want %0d",
                                                results_out, min_value, want.lo));
                    if (max_value !== want.hi)
                        flag_mismatch($sformatf("result %0d max_value got %0d want %0d",
                                                results_out, max_value, want.hi));
                    if (median_value !== want.mid)
                        flag_mismatch($sformatf("result %0d median_value got %0d want %0d",
                                                results_out, median_value, want.mid));
                    if (end_of_run !== want.eor)
                        flag_mismatch($sformatf("result %0d end_of_run got %b want %b",
                                                results_out, end_of_run, want.eor));
                end
                results_out++;
            end
            // watchdog: any transaction on either channel resets it
            if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no transaction for %0d cycles, %0d windows outstanding",
                         WATCHDOG_LIMIT, window_q.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Falling edge: sample driver
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            // a new transaction is offered only when the slot is free
            if (!sample_valid || in_taken)
            begin
                if (pend_q.size() != 0 && !(send_idle_en && $urandom_range(99) < IDLE_PCT))
                begin
                    nxt_item = pend_q.pop_front();
                    sample_valid <= 1'b1;
                    sample       <= nxt_item.value;
                    last         <= nxt_item.last;
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    // Falling edge: receiver stall, with one long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            result_stall <= 1'b1;
        end
        else if (hold_go && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= recv_idle_en && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_item(smm_pkg::sample_t v, logic lst);
        item_t it;
        it.value = v;
        it.last  = lst;
        pend_q.push_back(it);
    endtask

    // Register write at the falling edge, one cycle wide; only called idle.
    task automatic set_radius(smm_pkg::radius_t v);
        @(negedge clk);
        cfg_write_enable <= 1'b1;
        cfg_write_data   <= v;
        @(negedge clk);
        cfg_write_enable <= 1'b0;
        @(posedge clk);
    endtask

    // Wait until every transaction went in and every window came back.
    task automatic drain();
        do
            @(posedge clk);
        while (pend_q.size() != 0 || sample_valid || window_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Half the time extremes, zero or small values, so ties and saturation show up often.
    function automatic smm_pkg::sample_t pick_sample();
        int r;
        r = $urandom_range(9);
        case (r)
            0:       return smm_pkg::sample_t'(16'sh7fff);
            1:       return smm_pkg::sample_t'(16'sh8000);
            2:       return '0;
            3, 4:    return smm_pkg::sample_t'($urandom_range(8)) - smm_pkg::sample_t'(4);
            default: return smm_pkg::sample_t'($urandom);
        endcase
    endfunction

    // Random streams at one radius; the final stream may stay open so the
    // next radius lands mid-stream.
    task automatic queue_random_phase(smm_pkg::radius_t hw, int n_items, bit may_leave_open);
        int n;
        int len;
        bit open_end;
        set_radius(hw);
        n = 0;
        open_end = may_leave_open && ($urandom_range(2) == 0);
        while (n < n_items)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
            begin
                n++;
                queue_item(pick_sample(),
                           (i == len - 1) && !(open_end && n >= n_items));
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < smm_pkg::MAX_WINDOW; i++)
        begin
            taps[i] = '0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // directed: radius from reset, full-scale swings
        queue_item(smm_pkg::sample_t'(16'sh7fff), 1'b0);
        queue_item(smm_pkg::sample_t'(16'sh8000), 1'b0);
        queue_item(smm_pkg::sample_t'(16'sh7fff), 1'b0);
        queue_item(smm_pkg::sample_t'(16'sh8000), 1'b0);
        queue_item('0, 1'b1);
        // single-sample stream
        queue_item(smm_pkg::sample_t'(16'sh8000), 1'b1);
        drain();

        // stream shorter than the radius
        set_radius(smm_pkg::radius_t'(3));
        queue_item(smm_pkg::sample_t'(-1), 1'b0);
        queue_item(smm_pkg::sample_t'(16'sh7fff), 1'b1);
        drain();

        // zero radius behaves as one
        set_radius(smm_pkg::radius_t'(0));
        queue_item(smm_pkg::sample_t'(5), 1'b0);
        queue_item(smm_pkg::sample_t'(-5), 1'b0);
        queue_item(smm_pkg::sample_t'(1), 1'b1);
        drain();

        // radius changed in the middle of a stream
        set_radius(smm_pkg::radius_t'(2));
        queue_item(smm_pkg::sample_t'(100), 1'b0);
        queue_item(smm_pkg::sample_t'(-100), 1'b0);
        queue_item(smm_pkg::sample_t'(7), 1'b0);
        queue_item(smm_pkg::sample_t'(7), 1'b0);
        drain();
        set_radius(smm_pkg::radius_t'(3));
        queue_item(smm_pkg::sample_t'(16'sh8000), 1'b0);
        queue_item(smm_pkg::sample_t'(16'sh7fff), 1'b0);
        queue_item(smm_pkg::sample_t'(3), 1'b1);
        drain();

        // widest window, filled and flushed
        queue_item(smm_pkg::sample_t'(9), 1'b0);
        queue_item(smm_pkg::sample_t'(-9), 1'b0);
        queue_item(smm_pkg::sample_t'(2), 1'b0);
        queue_item(smm_pkg::sample_t'(2), 1'b0);
        queue_item(smm_pkg::sample_t'(16'sh7fff), 1'b0);
        queue_item(smm_pkg::sample_t'(16'sh8000), 1'b1);
        drain();

        // random phases across all radius codes
        queue_random_phase(smm_pkg::radius_t'(1), 25, 1'b1);
        drain();

        // pressure: sender never idles while the receiver holds off
        send_idle_en = 1'b0;
        hold_go      = 1'b1;
        queue_random_phase(smm_pkg::radius_t'(3), 25, 1'b1);
        drain();
        send_idle_en = 1'b1;

        queue_random_phase(smm_pkg::radius_t'(2), 25, 1'b1);
        drain();
        queue_random_phase(smm_pkg::radius_t'(0), 25, 1'b1);
        drain();

        // long stretch with no idling on either side
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        queue_random_phase(smm_pkg::radius_t'(3), 45, 1'b1);
        drain();
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;

        queue_random_phase(smm_pkg::radius_t'(2), 25, 1'b1);
        drain();
        queue_random_phase(smm_pkg::radius_t'(1), 25, 1'b1);
        drain();
        queue_random_phase(smm_pkg::radius_t'(3), 25, 1'b0);
        drain();

        $display("Covered %0d sample transactions in %0d closed streams, radius codes 0 to 3,",
                 items_in, streams);
        $display("mid-stream radius changes and a %0d-cycle receiver hold-off; %0d windows checked.",
                 HOLD_CYCLES, results_out);
        if (err_cnt == 0 && window_q.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("%0d mismatches, %0d windows outstanding", err_cnt, window_q.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
